/* rtl/rational_add_reduce_defines.svh */
// ----------------------------------------------------------------------------
// rational_add_reduce_defines : assertion macros
// clocked on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ADD_REDUCE_DEFINES_SVH
`define RATIONAL_ADD_REDUCE_DEFINES_SVH

// same-cycle implication
`define RAR_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rational_add_reduce: same-cycle check failed");

// next-cycle implication
`define RAR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rational_add_reduce: next-cycle check failed");

`endif

/* rtl/rar_pkg.sv */
// ----------------------------------------------------------------------------
// rar_pkg
// shared widths, payload types, microcode word and datapath flags
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rar_pkg;

  localparam int IN_WIDTH  = 16;
  localparam int DW        = 2 * IN_WIDTH;
  localparam int KW        = $clog2(DW + 1);
  localparam int CW        = $clog2(DW);
  localparam int NUM_WIDTH = 33;
  localparam int DEN_WIDTH = 31;
  localparam int EXT_WIDTH = 64;
  localparam int PC_WIDTH  = 4;

  typedef struct packed {
    logic signed [IN_WIDTH-1:0] a_num;
    logic signed [IN_WIDTH-1:0] a_den;
    logic signed [IN_WIDTH-1:0] b_num;
    logic signed [IN_WIDTH-1:0] b_den;
  } req_t;

  typedef struct packed {
    logic signed [NUM_WIDTH-1:0] sum_num;
    logic        [DEN_WIDTH-1:0] sum_den;
  } result_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_MUL_P1,
    OP_MUL_P2,
    OP_MUL_D,
    OP_SUM,
    OP_GLOAD,
    OP_HALVE2,
    OP_GSTEP,
    OP_GFIN,
    OP_DIV_LOAD_N,
    OP_DIV_STEP,
    OP_DIV_NEXT_D,
    OP_STORE_D,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_N_ZERO,
    C_BOTH_EVEN,
    C_X_NE_Y,
    C_CNT_NZ,
    C_END
  } cond_t;

  typedef struct packed {
    op_t                 op;
    cond_t               cond;
    logic [PC_WIDTH-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic n_zero;
    logic both_even;
    logic x_ne_y;
    logic cnt_nz;
  } flags_t;

endpackage

/* rtl/rar_datapath.sv */
// ----------------------------------------------------------------------------
// rar_datapath
// shared multiplier, sign-magnitude adder, binary gcd and restoring divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rar_datapath (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  rar_pkg::req_t   req,
  input  rar_pkg::ctrl_t  ctrl,
  output rar_pkg::flags_t flags,
  output logic            done,
  output rar_pkg::result_t result
);
  import rar_pkg::*;

  logic [IN_WIDTH-1:0] an, ad, bn, bd;
  logic                an_s, ad_s, bn_s, bd_s;
  logic [DW-1:0]       p1, p2, n, d, x, y, g, q, rem;
  logic                nneg, dneg;
  logic [KW-1:0]       k;
  logic [CW-1:0]       cnt;

  logic [IN_WIDTH-1:0] ma, mb;
  logic [DW-1:0]       prod;
  logic                p1_neg, p2_neg, p1_ge;
  logic [DW-1:0]       sum_mag;
  logic                sum_neg;
  logic                x_ge;
  logic [DW-1:0]       diff;
  logic [DW:0]         shr, trial;
  logic                rneg;
  logic [EXT_WIDTH-1:0] n_ext, num_wide, d_ext;

  function automatic logic [IN_WIDTH-1:0] mag_of(input logic [IN_WIDTH-1:0] v);
    mag_of = v[IN_WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  // multiplier operand select
  always_comb begin
    unique case (ctrl.op)
      OP_MUL_P1: begin
        ma = an;
        mb = bd;
      end
      OP_MUL_P2: begin
        ma = ad;
        mb = bn;
      end
      default: begin
        ma = ad;
        mb = bd;
      end
    endcase
  end

  assign prod = DW'(ma) * DW'(mb);

  // signed sum of the cross products
  always_comb begin
    p1_neg = (an_s ^ bd_s) && (p1 != '0);
    p2_neg = (ad_s ^ bn_s) && (p2 != '0);
    p1_ge  = (p1 >= p2);
    if (p1_neg == p2_neg) begin
      sum_mag = p1 + p2;
      sum_neg = p1_neg;
    end else if (p1_ge) begin
      sum_mag = p1 - p2;
      sum_neg = p1_neg;
    end else begin
      sum_mag = p2 - p1;
      sum_neg = p2_neg;
    end
  end

  assign x_ge  = (x >= y);
  assign diff  = x_ge ? (x - y) : (y - x);
  assign shr   = {rem, q[DW-1]};
  assign trial = shr - {1'b0, g};

  assign rneg     = (nneg ^ dneg) && (n != '0);
  assign n_ext    = EXT_WIDTH'(n);
  assign num_wide = rneg ? (EXT_WIDTH'(0) - n_ext) : n_ext;
  assign d_ext    = EXT_WIDTH'(d);

  assign flags.n_zero    = (n == '0);
  assign flags.both_even = !x[0] && !y[0];
  assign flags.x_ne_y    = (x != y);
  assign flags.cnt_nz    = (cnt != '0);

  always_ff @(posedge clk) begin
    if (load) begin
      an   <= mag_of(req.a_num);
      ad   <= mag_of(req.a_den);
      bn   <= mag_of(req.b_num);
      bd   <= mag_of(req.b_den);
      an_s <= req.a_num[IN_WIDTH-1];
      ad_s <= req.a_den[IN_WIDTH-1];
      bn_s <= req.b_num[IN_WIDTH-1];
      bd_s <= req.b_den[IN_WIDTH-1];
    end
    unique case (ctrl.op)
      OP_MUL_P1: p1 <= prod;
      OP_MUL_P2: p2 <= prod;
      OP_MUL_D:  d  <= prod;
      OP_SUM: begin
        n    <= sum_mag;
        nneg <= sum_neg;
        if (d == '0) begin
          d    <= DW'(1);
          dneg <= 1'b0;
        end else begin
          dneg <= ad_s ^ bd_s;
        end
      end
      OP_GLOAD: begin
        x <= n;
        y <= d;
        k <= '0;
      end
      OP_HALVE2: begin
        if (!x[0] && !y[0]) begin
          x <= x >> 1;
          y <= y >> 1;
          k <= k + 1'b1;
        end
      end
      OP_GSTEP: begin
        if (x != y) begin
          priority if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (x_ge) begin
            x <= diff >> 1;
          end else begin
            y <= diff >> 1;
          end
        end
      end
      OP_GFIN: g <= x << k;
      OP_DIV_LOAD_N: begin
        q   <= n;
        rem <= '0;
        cnt <= CW'(DW - 1);
      end
      OP_DIV_STEP: begin
        if (!trial[DW]) begin
          rem <= trial[DW-1:0];
          q   <= {q[DW-2:0], 1'b1};
        end else begin
          rem <= shr[DW-1:0];
          q   <= {q[DW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
      end
      OP_DIV_NEXT_D: begin
        n   <= q;
        q   <= d;
        rem <= '0;
        cnt <= CW'(DW - 1);
      end
      OP_STORE_D: d <= q;
      OP_EMIT: begin
        result.sum_num <= num_wide[NUM_WIDTH-1:0];
        result.sum_den <= d_ext[DEN_WIDTH-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (ctrl.op == OP_EMIT);
    end
  end

endmodule

/* rtl/rar_sequencer.sv */
// ----------------------------------------------------------------------------
// rar_sequencer
// step counter over a read-only microprogram with conditional jumps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rar_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  rar_pkg::flags_t flags,
  output logic            busy,
  output rar_pkg::ctrl_t  ctrl
);
  import rar_pkg::*;

  localparam logic [PC_WIDTH-1:0] L_HALVE = PC_WIDTH'(6);
  localparam logic [PC_WIDTH-1:0] L_GSTEP = PC_WIDTH'(7);
  localparam logic [PC_WIDTH-1:0] L_DIVN  = PC_WIDTH'(10);
  localparam logic [PC_WIDTH-1:0] L_DIVD  = PC_WIDTH'(12);
  localparam logic [PC_WIDTH-1:0] L_EMIT  = PC_WIDTH'(14);

  logic                running;
  logic [PC_WIDTH-1:0] pc, pc_next;
  ctrl_t               cw;
  logic                take;

  function automatic ctrl_t word(input op_t o, input cond_t c,
                                 input logic [PC_WIDTH-1:0] t);
    word = '{op: o, cond: c, target: t};
  endfunction

  function automatic ctrl_t rom(input logic [PC_WIDTH-1:0] a);
    unique case (a)
      PC_WIDTH'(0):  rom = word(OP_MUL_P1,     C_NEXT,      '0);
      PC_WIDTH'(1):  rom = word(OP_MUL_P2,     C_NEXT,      '0);
      PC_WIDTH'(2):  rom = word(OP_MUL_D,      C_NEXT,      '0);
      PC_WIDTH'(3):  rom = word(OP_SUM,        C_NEXT,      '0);
      PC_WIDTH'(4):  rom = word(OP_NOP,        C_N_ZERO,    L_EMIT);
      PC_WIDTH'(5):  rom = word(OP_GLOAD,      C_NEXT,      '0);
      L_HALVE:       rom = word(OP_HALVE2,     C_BOTH_EVEN, L_HALVE);
      L_GSTEP:       rom = word(OP_GSTEP,      C_X_NE_Y,    L_GSTEP);
      PC_WIDTH'(8):  rom = word(OP_GFIN,       C_NEXT,      '0);
      PC_WIDTH'(9):  rom = word(OP_DIV_LOAD_N, C_NEXT,      '0);
      L_DIVN:        rom = word(OP_DIV_STEP,   C_CNT_NZ,    L_DIVN);
      PC_WIDTH'(11): rom = word(OP_DIV_NEXT_D, C_NEXT,      '0);
      L_DIVD:        rom = word(OP_DIV_STEP,   C_CNT_NZ,    L_DIVD);
      PC_WIDTH'(13): rom = word(OP_STORE_D,    C_NEXT,      '0);
      L_EMIT:        rom = word(OP_EMIT,       C_END,       '0);
      default:       rom = word(OP_NOP,        C_END,       '0);
    endcase
  endfunction

  assign cw = rom(pc);

  always_comb begin
    unique case (cw.cond)
      C_N_ZERO:    take = flags.n_zero;
      C_BOTH_EVEN: take = flags.both_even;
      C_X_NE_Y:    take = flags.x_ne_y;
      C_CNT_NZ:    take = flags.cnt_nz;
      default:     take = 1'b0;
    endcase
    pc_next = take ? cw.target : pc + 1'b1;
  end

  assign ctrl = running ? cw : word(OP_NOP, C_NEXT, '0);
  assign busy = running;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      pc      <= '0;
    end else if (!running) begin
      running <= start;
      pc      <= '0;
    end else begin
      running <= (cw.cond != C_END);
      pc      <= pc_next;
    end
  end

endmodule

/* rtl/rational_add_reduce.sv */
// ----------------------------------------------------------------------------
// rational_add_reduce
// Adds two signed fractions a_num/a_den + b_num/b_den and returns the sum
// reduced by the gcd of its magnitudes, with the sign on the numerator and a
// positive denominator; a zero denominator product becomes 1, and a zero
// numerator leaves the denominator unreduced. A request is taken when start is
// high and busy is low; busy then stays high until the result appears for one
// cycle on result with done high, which the receiver must take as it comes.
// busy stays high while the microprogram runs, which skips the gcd and the
// divisions when the numerator is zero; done rises in the same cycle that busy
// falls. The microprogram runs one multiplier product, one gcd step or one
// quotient bit per cycle, with DW = 32 here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rational_add_reduce (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  rar_pkg::req_t    req,
  output logic             busy,
  output logic             done,
  output rar_pkg::result_t result
);
  import rar_pkg::*;

  ctrl_t  ctrl;
  flags_t flags;
  logic   load;

  assign load = start && !busy;

  rar_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .flags (flags),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  rar_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .req    (req),
    .ctrl   (ctrl),
    .flags  (flags),
    .done   (done),
    .result (result)
  );

endmodule

/* rtl/rar_checker.sv */
// ----------------------------------------------------------------------------
// rar_checker
// port-level checks on request and result timing and a nonzero result denominator, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rational_add_reduce_defines.svh"

module rar_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input rar_pkg::result_t result
);
  import rar_pkg::*;

  `RAR_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `RAR_ASSERT_NOW(a_done_idle, done, !busy)
  `RAR_ASSERT_NEXT(a_done_pulse, done, !done)
  `RAR_ASSERT_NOW(a_den_nonzero, done, result.sum_den != '0)
  `RAR_ASSERT_NOW(a_finish_done, $fell(busy) && !$past(rst), done)

endmodule

bind rational_add_reduce rar_checker u_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
